@@ design/prpu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package prpu_pkg;

  // Pack format codes
  localparam logic [2:0] FMT_U16_12    = 3'd0;
  localparam logic [2:0] FMT_U16_10    = 3'd1;
  localparam logic [2:0] FMT_PACKED12  = 3'd2;
  localparam logic [2:0] FMT_MIPI12    = 3'd3;
  localparam logic [2:0] FMT_SPACKED12 = 3'd4;
  localparam logic [2:0] FMT_SPACKED10 = 3'd5;

  localparam logic [2:0] FMT_RESET     = FMT_PACKED12;

  // Phase of the last byte slot in the largest group
  localparam logic [2:0] PHASE_MAX     = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_end;
  } byte_item_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic        last_of_group;
    logic        line_done;
  } pix_item_t;

  // One finished group handed to the output buffer
  typedef struct packed {
    logic [3:0][15:0] pix;
    logic [2:0]       cnt;
    logic             eol;
  } grp_t;

  // Bytes per group; zero for codes that are not a format
  function automatic logic [2:0] group_size(input logic [2:0] fmt);
    logic [2:0] n;
    case (fmt)
      FMT_U16_12, FMT_U16_10:                n = 3'd2;
      FMT_PACKED12, FMT_MIPI12, FMT_SPACKED12: n = 3'd3;
      FMT_SPACKED10:                         n = 3'd5;
      default:                               n = 3'd0;
    endcase
    return n;
  endfunction

  // Slice a complete group into left-aligned pixels
  function automatic grp_t unpack_group(input logic [2:0] fmt, input logic [39:0] g,
                                        input logic eol);
    grp_t r;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    b0 = g[7:0];
    b1 = g[15:8];
    b2 = g[23:16];
    r.pix = '0;
    r.eol = eol;
    case (fmt)
      FMT_U16_12: begin
        r.pix[0] = {b1[3:0], b0, 4'b0000};
        r.cnt    = 3'd1;
      end
      FMT_U16_10: begin
        r.pix[0] = {b1[1:0], b0, 6'b000000};
        r.cnt    = 3'd1;
      end
      FMT_PACKED12: begin
        r.pix[0] = {b0, b1[3:0], 4'b0000};
        r.pix[1] = {b2, b1[7:4], 4'b0000};
        r.cnt    = 3'd2;
      end
      FMT_MIPI12: begin
        r.pix[0] = {b0, b2[3:0], 4'b0000};
        r.pix[1] = {b1, b2[7:4], 4'b0000};
        r.cnt    = 3'd2;
      end
      FMT_SPACKED12: begin
        r.pix[0] = {b1[3:0], b0, 4'b0000};
        r.pix[1] = {b2, b1[7:4], 4'b0000};
        r.cnt    = 3'd2;
      end
      FMT_SPACKED10: begin
        r.pix[0] = {g[9:0], 6'b000000};
        r.pix[1] = {g[19:10], 6'b000000};
        r.pix[2] = {g[29:20], 6'b000000};
        r.pix[3] = {g[39:30], 6'b000000};
        r.cnt    = 3'd4;
      end
      default: begin
        r.cnt    = 3'd0;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/prpu_unpack.sv @@
`timescale 1ns / 1ps
`default_nettype none

module prpu_unpack (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_data,
  input  wire logic                 byte_valid,
  output logic                      byte_stall,
  input  wire prpu_pkg::byte_item_t byte_item,
  input  wire logic                 buf_free,
  output logic                      grp_load,
  output prpu_pkg::grp_t            grp
);
  import prpu_pkg::*;

  logic [2:0]  fmt;
  logic        s1_valid;
  byte_item_t  s1_item;
  logic [2:0]  phase;
  logic [31:0] group_bytes;

  logic [2:0]  n;
  logic [2:0]  ph_c;
  logic [39:0] g;
  logic        done;
  logic        s1_go;
  logic        accept;

  // Clamp phase and merge the new byte into the held group
  always_comb begin
    n     = group_size(fmt);
    ph_c  = (phase > PHASE_MAX) ? PHASE_MAX : phase;
    g     = {8'd0, group_bytes} | ({32'd0, s1_item.data_byte} << {ph_c, 3'b000});
    done  = (n != 3'd0) && (({1'b0, ph_c} + 4'd1) >= {1'b0, n});
    s1_go = s1_valid && (!done || buf_free);
  end

  assign accept     = byte_valid && !byte_stall;
  assign byte_stall = s1_valid && !s1_go;
  assign grp_load   = s1_valid && done && buf_free;
  assign grp        = unpack_group(fmt, g, s1_item.line_end);

  // Format register
  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= FMT_RESET;
    end else if (cfg_we) begin
      fmt <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_go);
    end
    if (accept) begin
      s1_item <= byte_item;
    end
  end

  // Advance phase and held bytes as each item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= 3'd0;
      group_bytes <= 32'd0;
    end else if (s1_go) begin
      if (n == 3'd0 || done || s1_item.line_end) begin
        phase       <= 3'd0;
        group_bytes <= 32'd0;
      end else begin
        phase       <= ph_c + 3'd1;
        group_bytes <= g[31:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ design/prpu_outbuf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module prpu_outbuf (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               grp_load,
  input  wire prpu_pkg::grp_t     grp,
  output logic                    buf_free,
  output logic                    pix_valid,
  input  wire logic               pix_stall,
  output prpu_pkg::pix_item_t     pix_item
);
  import prpu_pkg::*;

  logic [3:0][15:0] pix;
  logic [2:0]       cnt;
  logic             eol;
  logic             out_take;

  assign pix_valid = (cnt != 3'd0);
  assign out_take  = pix_valid && !pix_stall;
  assign buf_free  = (cnt == 3'd0) || ((cnt == 3'd1) && !pix_stall);

  // Head of the buffer is the next pixel
  always_comb begin
    pix_item.pixel         = pix[0];
    pix_item.last_of_group = (cnt == 3'd1);
    pix_item.line_done     = (cnt == 3'd1) && eol;
  end

  // Load a finished group or shift out one pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (grp_load) begin
      cnt <= grp.cnt;
    end else if (out_take) begin
      cnt <= cnt - 3'd1;
    end
    if (grp_load) begin
      pix <= grp.pix;
      eol <= grp.eol;
    end else if (out_take) begin
      pix <= {16'd0, pix[3], pix[2], pix[1]};
    end
  end

endmodule

`default_nettype wire

@@ design/packed_raw_pixel_unpacker_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                  Payload
// byte      byte_valid / byte_stall    byte_item  (data_byte, line_end)
// pixel     pix_valid  / pix_stall     pix_item   (pixel, last_of_group, line_done)
// config    cfg_we                     cfg_data   (pack_format)
//
// One byte is taken per cycle while byte_stall is low. A group's last byte passes
// the input register, then the group loads into the output buffer, which holds
// one group (up to four pixels) and drains a pixel a cycle while pix_stall is low.
// Synchronous active-high reset: empty pipeline, phase 0, format packed12.
// A stalled pixel side back-pressures the byte side only when a new group
// completes before the buffer has drained.

module packed_raw_pixel_unpacker_top (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_data,
  input  wire logic                 byte_valid,
  output logic                      byte_stall,
  input  wire prpu_pkg::byte_item_t byte_item,
  output logic                      pix_valid,
  input  wire logic                 pix_stall,
  output prpu_pkg::pix_item_t       pix_item
);
  import prpu_pkg::*;

  logic buf_free;
  logic grp_load;
  grp_t grp;

  prpu_unpack u_unpack (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .buf_free   (buf_free),
    .grp_load   (grp_load),
    .grp        (grp)
  );

  prpu_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .grp_load  (grp_load),
    .grp       (grp),
    .buf_free  (buf_free),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_item  (pix_item)
  );

endmodule

`default_nettype wire
